// ===== hdl/hrm_pkg.sv =====
// ----------------------------------------------------------------------------
// hrm_pkg: shared types and constants for the Hamming top-two matcher
// Request kinds, the queue entry between front and back, field widths.
// ----------------------------------------------------------------------------
package hrm_pkg;

	localparam int CODE_BITS_DEF = 128;
	localparam int MAX_DESC_DEF  = 4096;

	localparam int CODE_IN_W  = 128;
	localparam int ID_W       = 12;
	localparam int DIST_W     = 8;
	localparam int GATHER_W   = 13;
	localparam int TOTAL_W    = 16;
	localparam int RATIO_W    = 9;
	localparam int EPOCH_BITS = 8;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd205;

	// front/back queue, power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_CAND   = 2'd1,
		ACT_END    = 2'd2,
		ACT_IGNORE = 2'd3
	} act_t;

	typedef struct packed {
		act_t              kind;
		logic [ID_W-1:0]   id;
		logic [ID_W-1:0]   qidx;
		logic [DIST_W-1:0] ham;
	} op_t;

endpackage

// ===== hdl/hamming_top2_ratio_matcher.sv =====
// ----------------------------------------------------------------------------
// hamming_top2_ratio_matcher: hash-code top-two matcher with ratio test
//
//   channel  dir  handshake               payload
//   s_axis   in   s_axis_tvalid/tready    tuser: action; tdata: query, code, id
//   m_axis   out  m_axis_tvalid/tready    tuser: matched; tdata: query..total
//   cfg      in   cfg_we                  cfg_wdata: ratio_q8
//
// One request per cycle sustained unless intake stalls; an end request's result
// passes the two popcount stages, the queue, the rank stage and the output register.
// After reset the seen map is cleared over all SEEN_DEPTH entries (4096 at the
// default); the same pass repeats on every 255th begin when the 8-bit epoch
// wraps. During a pass requests fill the 4-entry queue, then intake stalls.
// A result waiting on m_axis holds the next end request in the rank stage;
// requests behind it back up into the queue, then intake stalls.
// ----------------------------------------------------------------------------
module hamming_top2_ratio_matcher #(
	parameter int CODE_BITS       = hrm_pkg::CODE_BITS_DEF,
	parameter int MAX_DESCRIPTORS = hrm_pkg::MAX_DESC_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [151:0] s_axis_tdata,  // query_index, code_low, code_high, cand id
	input  logic [1:0]   s_axis_tuser,  // action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata,  // match_query, best_id, best_distance, total_matches
	output logic [0:0]   m_axis_tuser,  // matched
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata
);

	import hrm_pkg::*;

	op_t               push_op;
	op_t               q_head;
	logic              push;
	logic              q_pop;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	logic              out_matched;
	logic [ID_W-1:0]   out_query;
	logic [ID_W-1:0]   out_best_id;
	logic [DIST_W-1:0] out_best_dist;
	logic [TOTAL_W-1:0] out_total;

	hrm_front #(
		.CODE_BITS (CODE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_query  (s_axis_tdata[11:0]),
		.in_code   ({s_axis_tdata[139:76], s_axis_tdata[75:12]}),
		.in_id     (s_axis_tdata[151:140]),
		.q_count   (q_count),
		.push      (push),
		.push_op   (push_op)
	);

	hrm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty),
		.count   (q_count)
	);

	hrm_back #(
		.MAX_DESCRIPTORS (MAX_DESCRIPTORS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_matched   (out_matched),
		.out_query     (out_query),
		.out_best_id   (out_best_id),
		.out_best_dist (out_best_dist),
		.out_total     (out_total)
	);

	assign m_axis_tdata = {out_total, out_best_dist, out_best_id, out_query};
	assign m_axis_tuser = out_matched;

endmodule

// ===== hdl/hrm_ram.sv =====
// ----------------------------------------------------------------------------
// hrm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/hrm_queue.sv =====
// ----------------------------------------------------------------------------
// hrm_queue: short request queue between front and back
// Register-based FIFO; the front never pushes into a full queue (credits).
// ----------------------------------------------------------------------------
module hrm_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  hrm_pkg::op_t              push_op,
	input  logic                      pop,
	output hrm_pkg::op_t              head,
	output logic                      empty,
	output logic [hrm_pkg::QCNT_W-1:0] count
);

	import hrm_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/hrm_front.sv =====
// ----------------------------------------------------------------------------
// hrm_front: request intake and distance computation
// Holds the query code, takes the XOR on intake, popcounts in two stages
// and pushes classified requests into the queue. Never stalls internally:
// intake is granted only when the queue has room for every request in flight.
// ----------------------------------------------------------------------------
module hrm_front #(
	parameter int CODE_BITS = hrm_pkg::CODE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_action,
	input  logic [hrm_pkg::ID_W-1:0]      in_query,
	input  logic [hrm_pkg::CODE_IN_W-1:0] in_code,
	input  logic [hrm_pkg::ID_W-1:0]      in_id,
	input  logic [hrm_pkg::QCNT_W-1:0]    q_count,
	output logic                          push,
	output hrm_pkg::op_t                  push_op
);

	import hrm_pkg::*;

	localparam int NCHUNK  = (CODE_BITS + 15) / 16;
	localparam int PAD_W   = NCHUNK * 16;
	localparam int CHUNK_W = 5;
	localparam int OCC_W   = QCNT_W + 1;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(v[i]);
		end
		return c;
	endfunction

	logic                 accept;
	act_t                 in_kind;
	logic [OCC_W-1:0]     occ;
	logic [CODE_BITS-1:0] query_code_q;

	logic                 vld_s1;
	act_t                 kind_s1;
	logic [ID_W-1:0]      id_s1;
	logic [ID_W-1:0]      qidx_s1;
	logic [CODE_BITS-1:0] diff_s1;

	logic                 vld_s2;
	act_t                 kind_s2;
	logic [ID_W-1:0]      id_s2;
	logic [ID_W-1:0]      qidx_s2;
	logic [CHUNK_W-1:0]   chunk_s2 [NCHUNK];

	logic [PAD_W-1:0]     diff_pad;
	logic [CHUNK_W-1:0]   chunk_d [NCHUNK];
	logic [DIST_W-1:0]    ham_sum;

	assign in_kind  = act_t'(in_action);
	assign occ      = OCC_W'(q_count) + OCC_W'(vld_s1) + OCC_W'(vld_s2);
	assign in_ready = (occ < OCC_W'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	assign diff_pad = PAD_W'(diff_s1);

	always_comb begin
		for (int c = 0; c < NCHUNK; c++) begin
			chunk_d[c] = CHUNK_W'(pop8(diff_pad[c*16 +: 8])) +
			             CHUNK_W'(pop8(diff_pad[c*16+8 +: 8]));
		end
	end

	always_comb begin
		ham_sum = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			ham_sum = ham_sum + DIST_W'(chunk_s2[c]);
		end
	end

	assign push    = vld_s2;
	assign push_op = '{kind: kind_s2, id: id_s2, qidx: qidx_s2, ham: ham_sum};

	always_ff @(posedge clk) begin
		kind_s1 <= in_kind;
		id_s1   <= in_id;
		qidx_s1 <= in_query;
		diff_s1 <= in_code[CODE_BITS-1:0] ^ query_code_q;
		kind_s2 <= kind_s1;
		id_s2   <= id_s1;
		qidx_s2 <= qidx_s1;
		for (int c = 0; c < NCHUNK; c++) begin
			chunk_s2[c] <= chunk_d[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_code_q <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
		end else begin
			// unused action code is taken and dropped here
			vld_s1 <= accept && (in_kind != ACT_IGNORE);
			vld_s2 <= vld_s1;
			if (accept && in_kind == ACT_BEGIN) begin
				query_code_q <= in_code[CODE_BITS-1:0];
			end
		end
	end

endmodule

// ===== hdl/hrm_back.sv =====
// ----------------------------------------------------------------------------
// hrm_back: duplicate filter, top-two ranking and ratio test
// Seen map is an epoch-tagged RAM; a begin bumps the epoch, a wrap of the
// epoch (and reset) runs a clearing pass over the RAM.
// ----------------------------------------------------------------------------
module hrm_back #(
	parameter int MAX_DESCRIPTORS = hrm_pkg::MAX_DESC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hrm_pkg::RATIO_W-1:0] cfg_wdata,
	input  logic                        q_empty,
	input  hrm_pkg::op_t                q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_matched,
	output logic [hrm_pkg::ID_W-1:0]    out_query,
	output logic [hrm_pkg::ID_W-1:0]    out_best_id,
	output logic [hrm_pkg::DIST_W-1:0]  out_best_dist,
	output logic [hrm_pkg::TOTAL_W-1:0] out_total
);

	import hrm_pkg::*;

	localparam int SEEN_DEPTH = (MAX_DESCRIPTORS < (1 << ID_W)) ? MAX_DESCRIPTORS : (1 << ID_W);
	localparam int AW         = $clog2(SEEN_DEPTH);
	localparam int PROD_W     = DIST_W + RATIO_W;

	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;
	localparam logic [AW-1:0]         SWEEP_LAST  = AW'(SEEN_DEPTH - 1);

	logic [RATIO_W-1:0]    ratio_q;
	logic                  sweep_q;
	logic [AW-1:0]         sweep_cnt_q;
	logic [EPOCH_BITS-1:0] epoch_q;

	logic                  vld_s1;
	op_t                   op_s1;

	logic                  byp_vld_q;
	logic [ID_W-1:0]       byp_id_q;

	logic [ID_W-1:0]       cur_query_q;
	logic [GATHER_W-1:0]   gath_q;
	logic [1:0]            uniq_q;
	logic [DIST_W-1:0]     first_d_q;
	logic [ID_W-1:0]       first_id_q;
	logic [DIST_W-1:0]     second_d_q;
	logic [ID_W-1:0]       second_id_q;
	logic [TOTAL_W-1:0]    total_q;

	logic                  out_vld_q;
	logic                  out_matched_q;
	logic [ID_W-1:0]       out_query_q;
	logic [ID_W-1:0]       out_best_id_q;
	logic [DIST_W-1:0]     out_best_dist_q;
	logic [TOTAL_W-1:0]    out_total_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [EPOCH_BITS-1:0] ram_wdata;
	logic [EPOCH_BITS-1:0] rd_tag;

	logic                  leave;
	logic                  wrap_hold;
	logic                  in_range;
	logic                  seen;
	logic                  fresh;
	logic [PROD_W-1:0]     lhs;
	logic [PROD_W-1:0]     rhs;
	logic                  ok;
	logic [TOTAL_W-1:0]    total_nx;

	// end request waits in s1 while the previous result is still pending
	assign leave     = vld_s1 && !(op_s1.kind == ACT_END && out_vld_q && !out_ready);
	assign wrap_hold = vld_s1 && op_s1.kind == ACT_BEGIN && epoch_q == EPOCH_LAST;
	assign q_pop     = !q_empty && !sweep_q && !wrap_hold && (!vld_s1 || leave);

	assign in_range = (32'(op_s1.id) < 32'(MAX_DESCRIPTORS));
	// the previous candidate's write lands the same edge this tag was read
	assign seen     = (rd_tag == epoch_q) || (byp_vld_q && byp_id_q == op_s1.id);
	assign fresh    = in_range && !seen;

	assign lhs      = PROD_W'({first_d_q, 8'h00});
	assign rhs      = PROD_W'(second_d_q) * PROD_W'(ratio_q);
	assign ok       = (gath_q > GATHER_W'(2)) && (uniq_q == 2'd2) && (lhs <= rhs);
	assign total_nx = (ok && total_q != '1) ? total_q + 1'b1 : total_q;

	assign ram_we    = sweep_q || (leave && op_s1.kind == ACT_CAND && in_range);
	assign ram_waddr = sweep_q ? sweep_cnt_q : op_s1.id[AW-1:0];
	assign ram_wdata = sweep_q ? '0 : epoch_q;

	hrm_ram #(
		.WIDTH (EPOCH_BITS),
		.DEPTH (SEEN_DEPTH)
	) u_seen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_head.id[AW-1:0]),
		.rdata (rd_tag)
	);

	assign out_valid     = out_vld_q;
	assign out_matched   = out_matched_q;
	assign out_query     = out_query_q;
	assign out_best_id   = out_best_id_q;
	assign out_best_dist = out_best_dist_q;
	assign out_total     = out_total_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_head;
		end
		if (leave && op_s1.kind == ACT_END) begin
			out_matched_q   <= ok;
			out_query_q     <= cur_query_q;
			out_best_id_q   <= ok ? first_id_q : '0;
			out_best_dist_q <= ok ? first_d_q : '0;
			out_total_q     <= total_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RATIO_RESET;
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			epoch_q     <= EPOCH_FIRST;
			vld_s1      <= 1'b0;
			byp_vld_q   <= 1'b0;
			byp_id_q    <= '0;
			cur_query_q <= '0;
			gath_q      <= '0;
			uniq_q      <= '0;
			first_d_q   <= '0;
			first_id_q  <= '0;
			second_d_q  <= '0;
			second_id_q <= '0;
			total_q     <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end

			if (sweep_q) begin
				if (sweep_cnt_q == SWEEP_LAST) begin
					sweep_q     <= 1'b0;
					sweep_cnt_q <= '0;
				end else begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
				end
			end

			if (q_pop) begin
				vld_s1 <= 1'b1;
			end else if (leave) begin
				vld_s1 <= 1'b0;
			end

			if (leave && op_s1.kind == ACT_END) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end

			if (leave) begin
				unique case (op_s1.kind)
					ACT_BEGIN: begin
						cur_query_q <= op_s1.qidx;
						gath_q      <= '0;
						uniq_q      <= '0;
						first_d_q   <= '0;
						first_id_q  <= '0;
						second_d_q  <= '0;
						second_id_q <= '0;
						byp_vld_q   <= 1'b0;
						if (epoch_q == EPOCH_LAST) begin
							sweep_q <= 1'b1;
							epoch_q <= EPOCH_FIRST;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
					ACT_CAND: begin
						if (gath_q != '1) begin
							gath_q <= gath_q + 1'b1;
						end
						if (in_range) begin
							byp_vld_q <= 1'b1;
							byp_id_q  <= op_s1.id;
						end
						if (fresh) begin
							if (uniq_q == 2'd0) begin
								first_d_q  <= op_s1.ham;
								first_id_q <= op_s1.id;
								uniq_q     <= 2'd1;
							end else begin
								// ties keep the earlier candidate
								if (op_s1.ham < first_d_q) begin
									second_d_q  <= first_d_q;
									second_id_q <= first_id_q;
									first_d_q   <= op_s1.ham;
									first_id_q  <= op_s1.id;
								end else if (uniq_q != 2'd2 || op_s1.ham < second_d_q) begin
									second_d_q  <= op_s1.ham;
									second_id_q <= op_s1.id;
								end
								uniq_q <= 2'd2;
							end
						end
					end
					ACT_END: begin
						total_q <= total_nx;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
